// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the symmetric FIR filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/sfir_pkg.sv =====
// Shared constants and controller/datapath types for the symmetric FIR filter.
package sfir_pkg;

  // Default sizes
  localparam int HALF_TAPS_DEF   = 10;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 16;

  // Fixed field widths
  localparam int CFG_W = 4;
  localparam int IDX_W = 4;

  // Reset value of the pair-count register
  localparam logic [CFG_W-1:0] HALF_IN_USE_RESET = 4'd10;

  // Word kinds carried on in_tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // store the sample, load the tap pointers
    logic coef_wr;   // write one coefficient
    logic step;      // read one tap pair and advance the pointers
    logic load_out;  // round, saturate and load the output register
  } sfir_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic k_zero;    // pointers sit on the centre tap
    logic acc_done;  // accumulator holds the complete sum
    logic out_free;  // output register can take a word this cycle
  } sfir_sts_t;

endpackage

// ===== rtl/sfir_ctrl.sv =====
// Controller state machine sequencing the tap reads of the symmetric FIR filter.
module sfir_ctrl
  import sfir_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  output sfir_cmd_t cmd,
  input  sfir_sts_t sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Decode commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_COEF) begin
            cmd.coef_wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd.step = 1'b1;
        if (sts.k_zero) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.acc_done && sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sfir_dp.sv =====
// Datapath of the symmetric FIR filter: delay line, coefficients, pre-add MAC and output.
module sfir_dp
  import sfir_pkg::*;
#(
  parameter int HALF_TAPS   = HALF_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfir_cmd_t                     cmd,
  output sfir_sts_t                     sts,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_wr_data,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [IDX_W-1:0]              coef_index,
  input  logic signed [COEF_BITS-1:0]   coef_value,
  output logic [SAMPLE_BITS-1:0]        filtered,
  output logic                          saturated,
  output logic                          out_valid,
  input  logic                          out_ready
);

  localparam int DEPTH  = 2 * HALF_TAPS + 1;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int K_W    = $clog2(HALF_TAPS + 1);
  localparam int PAIR_W = SAMPLE_BITS + 1;
  localparam int PROD_W = PAIR_W + COEF_BITS;
  localparam int ACC_W  = PROD_W + K_W + 1;
  localparam int SUM_W  = ACC_W + 1;
  localparam int RES_W  = SUM_W - (COEF_BITS - 1);
  localparam logic [SUM_W-1:0] RND = {{(SUM_W-1){1'b0}}, 1'b1} << (COEF_BITS - 2);

  // Pair-count register
  logic [CFG_W-1:0] half_r;
  logic [K_W-1:0]   m_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_IN_USE_RESET;
    end else if (cfg_wr_en) begin
      half_r <= cfg_wr_data;
    end
  end

  // Clamp the pair count to the built length
  always_comb begin
    if (32'(half_r) > 32'(HALF_TAPS)) begin
      m_eff = K_W'(HALF_TAPS);
    end else begin
      m_eff = K_W'(half_r);
    end
  end

  // Coefficient store
  logic signed [COEF_BITS-1:0] coef_arr_r [HALF_TAPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= HALF_TAPS; i++) begin
        coef_arr_r[i] <= '0;
      end
    end else if (cmd.coef_wr && (32'(coef_index) <= 32'(HALF_TAPS))) begin
      coef_arr_r[K_W'(coef_index)] <= coef_value;
    end
  end

  // Write pointer and tap pointers
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] a_r;
  logic [PTR_W-1:0] b_r;
  logic [K_W-1:0]   k_r;
  logic             first_pend_r;
  logic [PTR_W-1:0] two_m;
  logic [PTR_W:0]   wrap_sum;
  logic [PTR_W-1:0] start_a;

  assign two_m    = PTR_W'({m_eff, 1'b0});
  assign wrap_sum = {1'b0, wp_r} + (PTR_W+1)'(DEPTH) - {1'b0, two_m};
  assign start_a  = (wp_r >= two_m) ? (wp_r - two_m) : wrap_sum[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      first_pend_r <= 1'b0;
    end else if (cmd.start) begin
      wp_r         <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      first_pend_r <= 1'b1;
    end else if (cmd.step) begin
      first_pend_r <= 1'b0;
    end
  end

  // Start at the oldest and newest taps, walk inward to the centre
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r <= start_a;
      b_r <= wp_r;
      k_r <= m_eff;
    end else if (cmd.step) begin
      a_r <= (a_r == PTR_W'(DEPTH - 1)) ? '0 : a_r + 1'b1;
      b_r <= (b_r == '0) ? PTR_W'(DEPTH - 1) : b_r - 1'b1;
      k_r <= k_r - 1'b1;
    end
  end

  assign sts.k_zero = (k_r == '0);

  // Delay line memory, one write and two registered reads
  logic signed [SAMPLE_BITS-1:0] line_mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_a_r;
  logic signed [SAMPLE_BITS-1:0] rd_b_r;
  logic [DEPTH-1:0]              vld_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      line_mem[wp_r] <= sample;
    end
    if (cmd.step) begin
      rd_a_r <= line_mem[a_r];
      rd_b_r <= line_mem[b_r];
    end
  end

  // Stage 1 control: read valid bits and tap flags
  logic           v1_r, first1_r, last1_r, va1_r, vb1_r;
  logic [K_W-1:0] kid1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      v1_r     <= 1'b0;
      first1_r <= 1'b0;
      last1_r  <= 1'b0;
      va1_r    <= 1'b0;
      vb1_r    <= 1'b0;
    end else begin
      if (cmd.start) begin
        vld_r[wp_r] <= 1'b1;
      end
      v1_r <= cmd.step;
      if (cmd.step) begin
        first1_r <= first_pend_r;
        last1_r  <= (k_r == '0);
        va1_r    <= vld_r[a_r];
        vb1_r    <= vld_r[b_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      kid1_r <= k_r;
    end
  end

  // Stage 2: pre-add the pair, fetch its coefficient
  logic                      v2_r, first2_r, last2_r;
  logic signed [PAIR_W-1:0]  a_ext, b_ext;
  logic signed [PAIR_W-1:0]  pair_r;
  logic signed [COEF_BITS-1:0] coef_r;

  assign a_ext = va1_r ? PAIR_W'(rd_a_r) : '0;
  assign b_ext = (vb1_r && !last1_r) ? PAIR_W'(rd_b_r) : '0;

  always_ff @(posedge clk) begin
    if (v1_r) begin
      pair_r   <= a_ext + b_ext;
      coef_r   <= coef_arr_r[kid1_r];
      first2_r <= first1_r;
      last2_r  <= last1_r;
    end
  end

  // Stage 3: multiply
  logic                     v3_r, first3_r, last3_r;
  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (v2_r) begin
      prod_r   <= pair_r * coef_r;
      first3_r <= first2_r;
      last3_r  <= last2_r;
    end
  end

  // Stage 4: accumulate
  logic signed [ACC_W-1:0] acc_r;
  logic                    acc_done_r;

  always_ff @(posedge clk) begin
    if (v3_r) begin
      acc_r <= first3_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.start) begin
        acc_done_r <= 1'b0;
      end else if (v3_r && last3_r) begin
        acc_done_r <= 1'b1;
      end
    end
  end

  assign sts.acc_done = acc_done_r;

  // Round half up, drop the fraction, saturate
  logic [SUM_W-1:0]       sum;
  logic [RES_W-1:0]       res;
  logic                   ovf;
  logic [SAMPLE_BITS-1:0] filt_nxt;

  assign sum = SUM_W'(acc_r) + RND;
  assign res = sum[SUM_W-1:COEF_BITS-1];
  assign ovf = !((&res[RES_W-1:SAMPLE_BITS-1]) || !(|res[RES_W-1:SAMPLE_BITS-1]));

  always_comb begin
    if (!ovf) begin
      filt_nxt = res[SAMPLE_BITS-1:0];
    end else if (res[RES_W-1]) begin
      filt_nxt = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      filt_nxt = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // Output register
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] filtered_r;
  logic                   saturated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered_r  <= filt_nxt;
      saturated_r <= ovf;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign filtered     = filtered_r;
  assign saturated    = saturated_r;

endmodule

// ===== rtl/symmetric_fir_filter.sv =====
// Top level of the symmetric linear-phase FIR filter.
//
// Input words arrive on in_*: in_tuser selects the kind. A sample word stores
// the sample in the delay line and yields one filtered word on out_*; a
// coefficient word writes coefficient coef_index (centre is 0) and yields
// nothing. Coefficient writes with an index beyond HALF_TAPS are dropped.
// cfg_wr_en/cfg_wr_data set the number of coefficient pairs in use, M; values
// above HALF_TAPS act as HALF_TAPS. Write it only while the filter is idle.
// Timing: one shared pre-add multiply-accumulate walks the M+1 tap pairs, one
// pair a cycle, behind a registered two-port read of the delay line memory and
// a three-stage pre-add/multiply/accumulate pipe. out_tvalid rises as the
// finished sum loads into the output register, in the same cycle in which the
// filter is ready for the next word; no word is taken before that. A
// coefficient word keeps the filter idle. The output register frees the
// filter for the next word while a result waits; if the receiver stalls, the
// following sample holds its sum until out_tready frees the register.
// Reset (rst_n low, synchronous) clears the delay line, the coefficients and
// the write position, and sets the pair count to ten; no clearing pass.
`include "assert_macros.svh"

module symmetric_fir_filter
  import sfir_pkg::*;
#(
  parameter int HALF_TAPS   = HALF_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + IDX_W + COEF_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // sample, coef_index, coef_value, zero pad
  input  logic             in_tuser,   // opcode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // filtered, zero pad
  output logic             out_tuser,  // saturated
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  sfir_cmd_t cmd;
  sfir_sts_t sts;

  logic signed [SAMPLE_BITS-1:0] sample;
  logic [IDX_W-1:0]              coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;
  logic [SAMPLE_BITS-1:0]        filtered;

  // Unpack the input word
  assign sample     = in_tdata[SAMPLE_BITS-1:0];
  assign coef_index = in_tdata[SAMPLE_BITS+IDX_W-1:SAMPLE_BITS];
  assign coef_value = in_tdata[SAMPLE_BITS+IDX_W+COEF_BITS-1:SAMPLE_BITS+IDX_W];

  sfir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sfir_dp #(
    .HALF_TAPS   (HALF_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .sample      (sample),
    .coef_index  (coef_index),
    .coef_value  (coef_value),
    .filtered    (filtered),
    .saturated   (out_tuser),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready)
  );

  // Pad the result word
  assign out_tdata = OUT_W'(filtered);

  // A taken sample word makes the filter busy
  `ASSERT_NEXT(a_sample_busy, in_tvalid && in_tready && (in_tuser == OP_SAMPLE), !in_tready)
  // Tap reads never overlap acceptance of a word
  `ASSERT_SAME(a_step_busy, cmd.step, !in_tready)
  // The output register only loads a finished sum into a free slot
  `ASSERT_SAME(a_load_done, cmd.load_out, sts.acc_done && sts.out_free)
  // A finished sum stays finished until the next sample starts
  `ASSERT_NEXT(a_done_hold, sts.acc_done && !cmd.start, sts.acc_done)

endmodule
